// File: rtl/core/positional_insert_delete_list_assert.svh
// ----------------------------------------------------------------------------
// positional insert/delete list assertion macros
// concurrent assertion shorthands used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PIDL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PIDL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// shared widths, codes and word types of the positional list
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int POS_W    = 7;
    localparam int ITEM_W   = 32;
    localparam int READ_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_DELETE = 2'd1;
    localparam opcode_t OP_READ   = 2'd2;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_BAD_POS = 2'd1;
    localparam status_t ST_FULL    = 2'd2;

    typedef struct packed {
        opcode_t             opcode;
        logic [POS_W-1:0]    position;
        logic [ITEM_W-1:0]   item_value;
    } pidl_cmd_t;

    typedef struct packed {
        logic [READ_W-1:0]   read_value;
        status_t             status;
        logic [LEN_W-1:0]    list_length;
        logic                is_empty;
    } pidl_res_t;

endpackage

`default_nettype wire

// File: rtl/core/pidl_in_if.sv
// ----------------------------------------------------------------------------
// pidl_in_if
// command channel: opcode, position and payload word with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface pidl_in_if
    import pidl_pkg::*;
();

    logic                valid;
    logic                ready;
    opcode_t             opcode;
    logic [POS_W-1:0]    position;
    logic [ITEM_W-1:0]   item_value;

    modport source (output valid, output opcode, output position, output item_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input item_value,
                    output ready);

endinterface

`default_nettype wire

// File: rtl/core/pidl_out_if.sv
// ----------------------------------------------------------------------------
// pidl_out_if
// result channel: read word, status and list length with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface pidl_out_if
    import pidl_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [READ_W-1:0]   read_value;
    status_t             status;
    logic [LEN_W-1:0]    list_length;
    logic                is_empty;

    modport source (output valid, output read_value, output status, output list_length,
                    output is_empty, input ready);
    modport sink   (input valid, input read_value, input status, input list_length,
                    input is_empty, output ready);

endinterface

`default_nettype wire

// File: rtl/core/pidl_ram.sv
// ----------------------------------------------------------------------------
// pidl_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/pidl_ctrl.sv
// ----------------------------------------------------------------------------
// pidl_ctrl
// list sequencer: decodes a command, moves entries one slot per cycle
// through the entry ram and builds the result word
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_ctrl
    import pidl_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire pidl_cmd_t cmd,
    output logic           res_valid,
    input  wire logic      res_ready,
    output pidl_res_t      res
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SHIFT  = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 up_reg, up_next;
    logic [ADDR_W-1:0]    src_reg, src_next;
    logic [ADDR_W-1:0]    dst_reg, dst_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic                 pend_reg, pend_next;
    logic [ADDR_W-1:0]    ins_addr_reg, ins_addr_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    pidl_res_t            res_reg, res_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 accept;
    logic [CMP_W-1:0]     pos_x;
    logic [CMP_W-1:0]     cnt_x;
    logic                 pos_zero;
    logic                 ins_pos_ok;
    logic                 sel_pos_ok;
    logic                 full;
    logic [ADDR_W-1:0]    pos_addr;
    logic [CNT_W-1:0]     cnt_after;
    pidl_res_t            res_bad;

    pidl_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_ready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && res_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // position checks against the current length
    assign pos_x      = CMP_W'(cmd.position);
    assign cnt_x      = CMP_W'(count_reg);
    assign pos_zero   = (cmd.position == '0);
    assign ins_pos_ok = !pos_zero && (pos_x <= cnt_x + CMP_W'(1));
    assign sel_pos_ok = !pos_zero && (pos_x <= cnt_x);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign pos_addr   = ADDR_W'(pos_x - CMP_W'(1));
    assign cnt_after  = up_reg ? (count_reg + CNT_W'(1)) : (count_reg - CNT_W'(1));

    always_comb
    begin
        res_bad.read_value  = '0;
        res_bad.status      = ST_BAD_POS;
        res_bad.list_length = LEN_W'(count_reg);
        res_bad.is_empty    = (count_reg == '0);
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        up_next       = up_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        rem_next      = rem_reg;
        pend_next     = pend_reg;
        ins_addr_next = ins_addr_reg;
        word_next     = word_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = dst_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = src_reg;

        case (state_reg)
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // write back the entry read last cycle one slot over
                ram_we = pend_reg;
                if (rem_reg != '0)
                begin
                    src_next  = up_reg ? (src_reg - ADDR_W'(1)) : (src_reg + ADDR_W'(1));
                    dst_next  = up_reg ? (src_reg + ADDR_W'(1)) : (src_reg - ADDR_W'(1));
                    rem_next  = rem_reg - CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // insert needs the write port free for the new word
                if ((rem_reg == '0) && (!pend_reg || !up_reg))
                begin
                    if (up_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ins_addr_reg;
                        ram_wdata = word_reg;
                    end
                    count_next           = cnt_after;
                    res_next.read_value  = '0;
                    res_next.status      = ST_OK;
                    res_next.list_length = LEN_W'(cnt_after);
                    res_next.is_empty    = (cnt_after == '0);
                    state_next           = S_DONE;
                end
            end
            S_RDWAIT:
            begin
                res_next.read_value  = READ_W'(ram_rdata);
                res_next.status      = ST_OK;
                res_next.list_length = LEN_W'(count_reg);
                res_next.is_empty    = (count_reg == '0);
                state_next           = S_DONE;
            end
            default:
            begin
            end
        endcase

        if (accept)
        begin
            case (cmd.opcode)
                OP_INSERT:
                begin
                    if (!ins_pos_ok)
                    begin
                        res_next   = res_bad;
                        state_next = S_DONE;
                    end
                    else if (full)
                    begin
                        res_next        = res_bad;
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        up_next       = 1'b1;
                        src_next      = ADDR_W'(cnt_x - CMP_W'(1));
                        rem_next      = CNT_W'(cnt_x - pos_x + CMP_W'(1));
                        pend_next     = 1'b0;
                        ins_addr_next = pos_addr;
                        word_next     = WORD_BITS'(cmd.item_value);
                        state_next    = S_SHIFT;
                    end
                end
                OP_DELETE:
                begin
                    if (!sel_pos_ok)
                    begin
                        res_next   = res_bad;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        up_next    = 1'b0;
                        src_next   = ADDR_W'(pos_x);
                        rem_next   = CNT_W'(cnt_x - pos_x);
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
                OP_READ:
                begin
                    if (!sel_pos_ok)
                    begin
                        res_next   = res_bad;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_raddr  = pos_addr;
                        state_next = S_RDWAIT;
                    end
                end
                default:
                begin
                    res_next   = res_bad;
                    state_next = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg       <= up_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        rem_reg      <= rem_next;
        ins_addr_reg <= ins_addr_next;
        word_reg     <= word_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/positional_insert_delete_list.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// ordered list of up to DEPTH words with insert, delete and read by position
// ----------------------------------------------------------------------------
// The list lives in one synchronous ram; positions count from 1. Insert at
// positions 1..length+1 moves later words up, delete at 1..length closes the
// gap, read returns the word at 1..length. A bad position (or an unused
// opcode) gives status 1 and changes nothing; insert into a full list gives
// status 2. Every command gives exactly one result word carrying the length
// and an empty flag after the command. One command is worked at a time.
// A command that fails its check goes straight to its result, and a read waits
// for the registered ram read; insert and delete move one entry per cycle
// through the single ram write port, and an insert then writes the new word.
// The result word loads into the output register at the edge from which the
// next command can be taken. A result waits in an output register, so the
// next command is taken while it is unread.
// Entries carry no reset: the list starts empty and only written slots are
// ever read, so no clearing pass is needed.
`default_nettype none

`include "positional_insert_delete_list_assert.svh"

module positional_insert_delete_list
    import pidl_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pidl_in_if.sink     req,
    pidl_out_if.source  rsp
);

    pidl_cmd_t cmd;
    logic      res_valid;
    logic      res_ready;
    pidl_res_t res;

    // output register
    logic      out_valid_reg, out_valid_next;
    pidl_res_t out_word_reg;

    // command word straight from the channel
    always_comb
    begin
        cmd.opcode     = req.opcode;
        cmd.position   = req.position;
        cmd.item_value = req.item_value;
    end

    // sequencer plus entry ram
    pidl_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (req.valid),
        .cmd_ready (req.ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // the result slot frees when empty or when the sink takes its word
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload loads only with a new result word
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_word_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_word_reg.read_value;
    assign rsp.status      = out_word_reg.status;
    assign rsp.list_length = out_word_reg.list_length;
    assign rsp.is_empty    = out_word_reg.is_empty;

    // failed commands never report data
    `PIDL_ASSERT_IMP(a_fail_no_data, clk, rst_n, rsp.valid && (rsp.status != ST_OK),
        rsp.read_value == '0, "failed command reported a nonzero read word")
    // a full report only comes from a list at capacity
    `PIDL_ASSERT_IMP(a_full_length, clk, rst_n, rsp.valid && (rsp.status == ST_FULL),
        rsp.list_length == LEN_W'(DEPTH), "full status with list below capacity")
    // a handed-over result shows on the output next cycle
    `PIDL_ASSERT_NXT(a_res_shown, clk, rst_n, res_valid && res_ready,
        rsp.valid, "result word lost in the output register")
    // a blocked result is held unchanged by the sequencer
    `PIDL_ASSERT_NXT(a_res_held, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res), "blocked result word changed or dropped")

endmodule

`default_nettype wire
